// ===== hw/rtl/obb_pkg.sv =====
// Shared types, constants and helpers for the oriented-box overlap test.
// Used by obb_front, obb_back and obb_overlap_test_2d_core. No dependencies.
`default_nettype none

package obb_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned UNIT_W      = 18;
  localparam int unsigned HALF_W      = 31;
  localparam logic [HALF_W-1:0] SAT_MAX = {HALF_W{1'b1}};

  typedef struct packed {
    logic                     is_second;
    logic signed [31:0]       center_x;
    logic signed [31:0]       center_y;
    logic signed [31:0]       axis_u_x;
    logic signed [31:0]       axis_u_y;
    logic signed [31:0]       axis_v_x;
    logic signed [31:0]       axis_v_y;
    logic [HALF_W-1:0]        half_u;
    logic [HALF_W-1:0]        half_v;
  } box_t;

  typedef struct packed {
    logic valid;
    box_t data;
  } queue_head_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_SQRT,
    ST_DIVX,
    ST_DIVY,
    ST_SIGN,
    ST_STORE,
    ST_PROJ,
    ST_DONE
  } back_state_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] abs_half(input logic signed [31:0] v);
    logic [31:0] m;
    m = mag32(v);
    return m[31] ? SAT_MAX : m[HALF_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/obb_front.sv =====
// Input stage: accepts box transfers, takes the absolute half extents and
// queues the boxes for the back end. Depends on obb_pkg.
`default_nettype none

module obb_front #(
  parameter int unsigned Depth = obb_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [255:0]        in_tdata,
  input  wire logic [0:0]          in_tuser,
  output obb_pkg::queue_head_t     head,
  input  wire logic                pop
);
  import obb_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  box_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            push, do_pop;
  box_t            item;

  assign in_tready = (count_r != CntW'(Depth));
  assign push      = in_tvalid && in_tready;
  assign do_pop    = pop && (count_r != '0);

  always_comb begin
    item.is_second = in_tuser[0];
    item.center_x  = $signed(in_tdata[31:0]);
    item.center_y  = $signed(in_tdata[63:32]);
    item.axis_u_x  = $signed(in_tdata[95:64]);
    item.axis_u_y  = $signed(in_tdata[127:96]);
    item.axis_v_x  = $signed(in_tdata[159:128]);
    item.axis_v_y  = $signed(in_tdata[191:160]);
    item.half_u    = abs_half($signed(in_tdata[223:192]));
    item.half_v    = abs_half($signed(in_tdata[255:224]));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head.valid = (count_r != '0);
  assign head.data  = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== hw/rtl/obb_back.sv =====
// Sequencer: normalises the box axes with a bit-serial square root and
// divider, then holds a first box, or runs the four axis tests for a second
// box on one shared multiplier. Depends on obb_pkg.
`default_nettype none

module obb_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  obb_pkg::queue_head_t     head,
  output logic                     pop,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [7:0]               out_tdata
);
  import obb_pkg::*;

  back_state_t state_r, state_nxt;

  box_t                      item_r;
  logic signed [31:0]        d_r [2];
  logic                      vec_r;
  logic [63:0]               sq_r;
  logic [32:0]               rem_r;
  logic [31:0]               root_r;
  logic [31:0]               drem_r;
  logic [16:0]               num_r;
  logic [16:0]               q_r, qx_r;
  logic [4:0]                cnt_r;
  logic signed [UNIT_W-1:0]  new_r [4];
  logic signed [31:0]        held_cx_r, held_cy_r;
  logic signed [UNIT_W-1:0]  held_unit_r [4];
  logic [HALF_W-1:0]         held_half_r [2];
  logic signed [63:0]        prod_r, acc_r;
  logic [1:0]                axis_r;
  logic [3:0]                ph_r;
  logic [HALF_W-1:0]         t_r, r_r;
  logic                      sep_r;
  logic                      out_valid_r, out_bit_r;
  logic                      fire;

  logic signed [31:0]        cur_x, cur_y;
  logic [31:0]               ax, ay;
  logic signed [32:0]        mul_a, mul_b;
  logic signed [65:0]        prod_full;
  logic [34:0]               rem_sh, trial;
  logic                      sq_ge;
  logic [32:0]               drem_sh;
  logic                      div_ge;
  logic [16:0]               q_nxt;
  logic [63:0]               acc_mag;
  logic [HALF_W-1:0]         prod_sat, dist_sat;
  logic [HALF_W+1:0]         r_sum;
  logic signed [UNIT_W-1:0]  n0, n1, m1x, m1y, m2x, m2y;
  logic [HALF_W-1:0]         h1, h2, own;
  logic signed [32:0]        dx_diff, dy_diff;
  logic signed [31:0]        dx_sat, dy_sat;
  logic signed [UNIT_W-1:0]  ux_s, uy_s;

  // Operand selection
  always_comb begin
    cur_x = vec_r ? item_r.axis_v_x : item_r.axis_u_x;
    cur_y = vec_r ? item_r.axis_v_y : item_r.axis_u_y;
    ax    = mag32(cur_x);
    ay    = mag32(cur_y);

    unique case (axis_r)
      2'd0: begin n0 = held_unit_r[0]; n1 = held_unit_r[1]; own = held_half_r[0]; end
      2'd1: begin n0 = held_unit_r[2]; n1 = held_unit_r[3]; own = held_half_r[1]; end
      2'd2: begin n0 = new_r[0]; n1 = new_r[1]; own = item_r.half_u; end
      default: begin n0 = new_r[2]; n1 = new_r[3]; own = item_r.half_v; end
    endcase
    if (!axis_r[1]) begin
      m1x = new_r[0]; m1y = new_r[1]; m2x = new_r[2]; m2y = new_r[3];
      h1  = item_r.half_u; h2 = item_r.half_v;
    end else begin
      m1x = held_unit_r[0]; m1y = held_unit_r[1];
      m2x = held_unit_r[2]; m2y = held_unit_r[3];
      h1  = held_half_r[0]; h2 = held_half_r[1];
    end

    acc_mag = acc_r[63] ? 64'(-acc_r) : 64'(acc_r);

    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQ0: begin mul_a = $signed({1'b0, ax}); mul_b = $signed({1'b0, ax}); end
      ST_SQ1: begin mul_a = $signed({1'b0, ay}); mul_b = $signed({1'b0, ay}); end
      ST_PROJ: begin
        unique case (ph_r)
          4'd0: begin mul_a = 33'(n0); mul_b = 33'(m1x); end
          4'd1: begin mul_a = 33'(n1); mul_b = 33'(m1y); end
          4'd3: begin
            mul_a = $signed({15'd0, acc_mag[33:16]});
            mul_b = $signed({2'b0, h1});
          end
          4'd5: begin mul_a = 33'(n0); mul_b = 33'(m2x); end
          4'd6: begin mul_a = 33'(n1); mul_b = 33'(m2y); end
          4'd8: begin
            mul_a = $signed({15'd0, acc_mag[33:16]});
            mul_b = $signed({2'b0, h2});
          end
          4'd9: begin mul_a = 33'(d_r[0]); mul_b = 33'(n0); end
          4'd10: begin mul_a = 33'(d_r[1]); mul_b = 33'(n1); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod_full = mul_a * mul_b;

    rem_sh  = {rem_r, sq_r[63:62]};
    trial   = {1'b0, root_r, 2'b01};
    sq_ge   = (rem_sh >= trial);
    drem_sh = {drem_r, num_r[16]};
    div_ge  = (drem_sh >= {1'b0, root_r});
    q_nxt   = {q_r[15:0], div_ge};

    prod_sat = (prod_r[63:16] > 48'(SAT_MAX)) ? SAT_MAX : prod_r[16+HALF_W-1:16];
    dist_sat = (acc_mag[63:16] > 48'(SAT_MAX)) ? SAT_MAX : acc_mag[16+HALF_W-1:16];
    r_sum    = (HALF_W+2)'(own) + (HALF_W+2)'(t_r) + (HALF_W+2)'(prod_sat);

    dx_diff = 33'(held_cx_r) - 33'(head.data.center_x);
    dy_diff = 33'(held_cy_r) - 33'(head.data.center_y);
    dx_sat  = (dx_diff[32] != dx_diff[31]) ? {dx_diff[32], {31{~dx_diff[32]}}}
                                           : dx_diff[31:0];
    dy_sat  = (dy_diff[32] != dy_diff[31]) ? {dy_diff[32], {31{~dy_diff[32]}}}
                                           : dy_diff[31:0];

    ux_s = (root_r == '0) ? '0
         : (cur_x[31] ? -$signed({1'b0, qx_r}) : $signed({1'b0, qx_r}));
    uy_s = (root_r == '0) ? '0
         : (cur_y[31] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r}));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (head.valid) state_nxt = ST_SQ0;
      ST_SQ0:   state_nxt = ST_SQ1;
      ST_SQ1:   state_nxt = ST_SQ2;
      ST_SQ2:   state_nxt = ST_SQRT;
      ST_SQRT:  if (cnt_r == '0) state_nxt = ST_DIVX;
      ST_DIVX:  if (cnt_r == '0) state_nxt = ST_DIVY;
      ST_DIVY:  if (cnt_r == '0) state_nxt = ST_SIGN;
      ST_SIGN: begin
        priority if (!vec_r) state_nxt = ST_SQ0;
        else if (item_r.is_second) state_nxt = ST_PROJ;
        else state_nxt = ST_STORE;
      end
      ST_STORE: state_nxt = ST_IDLE;
      ST_PROJ:  if (ph_r == 4'd12 && axis_r == 2'd3) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop  = (state_r == ST_IDLE) && head.valid;
    fire = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      held_cx_r   <= '0;
      held_cy_r   <= '0;
      for (int i = 0; i < 4; i++) held_unit_r[i] <= '0;
      held_half_r[0] <= '0;
      held_half_r[1] <= '0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_STORE) begin
        held_cx_r <= item_r.center_x;
        held_cy_r <= item_r.center_y;
        for (int i = 0; i < 4; i++) held_unit_r[i] <= new_r[i];
        held_half_r[0] <= item_r.half_u;
        held_half_r[1] <= item_r.half_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(prod_full[63:0]);
    if (fire) begin
      out_bit_r <= ~sep_r;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          item_r <= head.data;
          d_r[0] <= dx_sat;
          d_r[1] <= dy_sat;
          vec_r  <= 1'b0;
        end
      end
      ST_SQ1: sq_r <= $unsigned(prod_r);
      ST_SQ2: begin
        sq_r   <= sq_r + $unsigned(prod_r);
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= 5'd31;
      end
      ST_SQRT: begin
        sq_r   <= {sq_r[61:0], 2'b00};
        rem_r  <= sq_ge ? 33'(rem_sh - trial) : rem_sh[32:0];
        root_r <= {root_r[30:0], sq_ge};
        if (cnt_r == '0) begin
          drem_r <= {1'b0, ax[31:1]};
          num_r  <= {ax[0], 16'd0};
          q_r    <= '0;
          cnt_r  <= 5'd16;
        end else begin
          cnt_r  <= cnt_r - 1'b1;
        end
      end
      ST_DIVX, ST_DIVY: begin
        if (cnt_r == '0 && state_r == ST_DIVX) begin
          qx_r   <= q_nxt;
          drem_r <= {1'b0, ay[31:1]};
          num_r  <= {ay[0], 16'd0};
          q_r    <= '0;
          cnt_r  <= 5'd16;
        end else begin
          drem_r <= div_ge ? 32'(drem_sh - {1'b0, root_r}) : drem_sh[31:0];
          num_r  <= {num_r[15:0], 1'b0};
          q_r    <= q_nxt;
          cnt_r  <= cnt_r - 1'b1;
        end
      end
      ST_SIGN: begin
        new_r[{vec_r, 1'b0}] <= ux_s;
        new_r[{vec_r, 1'b1}] <= uy_s;
        vec_r  <= 1'b1;
        axis_r <= '0;
        ph_r   <= '0;
        sep_r  <= 1'b0;
      end
      ST_PROJ: begin
        ph_r <= (ph_r == 4'd12) ? '0 : ph_r + 1'b1;
        unique case (ph_r)
          4'd1, 4'd6, 4'd10: acc_r <= prod_r;
          4'd2, 4'd7, 4'd11: acc_r <= acc_r + prod_r;
          4'd4: t_r <= prod_sat;
          4'd9: r_r <= (r_sum > (HALF_W+2)'(SAT_MAX)) ? SAT_MAX : r_sum[HALF_W-1:0];
          4'd12: begin
            if (dist_sat > r_r) sep_r <= 1'b1;
            axis_r <= axis_r + 1'b1;
          end
          default: begin end
        endcase
      end
      default: begin end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_bit_r};

endmodule

`default_nettype wire

// ===== hw/rtl/obb_overlap_test_2d_core.sv =====
// Top level of the two-dimensional oriented-box overlap test.
// Instantiates obb_front and obb_back; depends on obb_pkg.
//
//   Channel | Direction | Signals                       | Content
//   in_     | input     | tvalid tready tdata tuser     | one box, tuser = is_second
//   out_    | output    | tvalid tready tdata           | overlap flag
//
// A first box is held and gives no result; a second box gives one result.
// The work runs through the bit-serial square root (32 steps), the divider
// (17 steps per component) and the axis tests on the one multiplier.
// Reset is synchronous and active low and clears the held box to zero.
// A short queue keeps taking transfers while the sequencer is busy, and the
// output register holds a result until it is taken.
`default_nettype none

module obb_overlap_test_2d_core #(
  parameter int unsigned QueueDepth = obb_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // center_x, center_y, axis_u_x, axis_u_y, axis_v_x, axis_v_y, half_u, half_v
  input  wire logic [255:0] in_tdata,
  // is_second
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // overlap, then seven zero bits
  output logic [7:0]        out_tdata
);
  import obb_pkg::*;

  queue_head_t head;
  logic        pop;

  obb_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .head     (head),
    .pop      (pop)
  );

  obb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_obb_overlap_test_2d_core.sv =====
// Self-checking testbench for obb_overlap_test_2d_core, the 2D oriented-box separating-axis test.
// It predicts each overlap flag in exact integer arithmetic and compares it with the block's output.
// Depends on obb_overlap_test_2d_core and its package obb_pkg.
`timescale 1ns / 1ps

module tb_obb_overlap_test_2d_core;

  localparam longint SAT_LIMIT = 64'h7FFF_FFFF;

  typedef struct {
    bit                 is_second;
    logic signed [31:0] cx, cy, ux, uy, vx, vy, hu, hv;
  } shape_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;

  // Held first box of the predictor.
  longint held_cx, held_cy, held_ux, held_uy, held_vx, held_vy, held_hu, held_hv;
  bit     overlap_q[$];
  int     errors = 0;
  bit     tx_gaps = 1'b1;
  bit     rx_stalls = 1'b1;
  bit     long_hold = 1'b0;

  always #2 clk = ~clk;

  obb_overlap_test_2d_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic normalise(input longint x, input longint y, output longint ox,
                           output longint oy);
    longint unsigned ax, ay, len;
    ax = magnitude(x);
    ay = magnitude(y);
    len = int_sqrt(ax * ax + ay * ay);
    if (len == 0) begin
      ox = 0;
      oy = 0;
    end else begin
      ox = longint'((ax << 16) / len);
      oy = longint'((ay << 16) / len);
      if (x < 0) ox = -ox;
      if (y < 0) oy = -oy;
    end
  endtask

  function automatic longint abs_extent(longint h);
    longint a;
    a = magnitude(h);
    return a > SAT_LIMIT ? SAT_LIMIT : a;
  endfunction

  function automatic longint edge_radius(longint nx, longint ny, longint mx, longint my,
                                         longint h);
    longint a;
    a = magnitude(nx * mx + ny * my) >> 16;
    a = (a * h) >> 16;
    return a > SAT_LIMIT ? SAT_LIMIT : a;
  endfunction

  function automatic bit axis_separates(longint nx, longint ny, longint dx, longint dy,
                                        longint own, longint m1x, longint m1y,
                                        longint m2x, longint m2y, longint h1, longint h2);
    longint r, proj_dist;
    r = own + edge_radius(nx, ny, m1x, m1y, h1) + edge_radius(nx, ny, m2x, m2y, h2);
    if (r > SAT_LIMIT) r = SAT_LIMIT;
    proj_dist = magnitude(dx * nx + dy * ny) >> 16;
    if (proj_dist > SAT_LIMIT) proj_dist = SAT_LIMIT;
    return proj_dist > r;
  endfunction

  function automatic longint sat_diff(longint a, longint b);
    longint d;
    d = a - b;
    if (d > SAT_LIMIT) d = SAT_LIMIT;
    if (d < -SAT_LIMIT - 1) d = -SAT_LIMIT - 1;
    return d;
  endfunction

  task automatic predict_overlap(input shape_t s);
    longint ux, uy, vx, vy, hu, hv, dx, dy;
    bit     sep;
    normalise(s.ux, s.uy, ux, uy);
    normalise(s.vx, s.vy, vx, vy);
    hu = abs_extent(s.hu);
    hv = abs_extent(s.hv);
    if (!s.is_second) begin
      held_cx = s.cx;
      held_cy = s.cy;
      held_ux = ux;
      held_uy = uy;
      held_vx = vx;
      held_vy = vy;
      held_hu = hu;
      held_hv = hv;
    end else begin
      dx = sat_diff(held_cx, s.cx);
      dy = sat_diff(held_cy, s.cy);
      sep = axis_separates(held_ux, held_uy, dx, dy, held_hu, ux, uy, vx, vy, hu, hv)
         || axis_separates(held_vx, held_vy, dx, dy, held_hv, ux, uy, vx, vy, hu, hv)
         || axis_separates(ux, uy, dx, dy, hu, held_ux, held_uy, held_vx, held_vy,
                           held_hu, held_hv)
         || axis_separates(vx, vy, dx, dy, hv, held_ux, held_uy, held_vx, held_vy,
                           held_hu, held_hv);
      overlap_q.push_back(!sep);
    end
  endtask

  task automatic send_box(input shape_t s);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= s.is_second;
    in_tdata  <= {s.hv, s.hu, s.vy, s.vx, s.uy, s.ux, s.cy, s.cx};
    do @(posedge clk); while (!in_tready);
    predict_overlap(s);
  endtask

  function automatic logic [31:0] rand_value(int span);
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3, 4: return $urandom();
      default: return 32'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  // Sensible boxes near the origin so that both overlap outcomes are common, or noisy ones over the full range.
  function automatic shape_t rand_box(bit second, bit noisy);
    shape_t s;
    int     span;
    span = noisy ? 32'h7FFF_FFFF : (1 << 20);
    s.is_second = second;
    s.cx = noisy ? rand_value(span) : 32'($signed($urandom_range(0, 2 * span)) - span);
    s.cy = noisy ? rand_value(span) : 32'($signed($urandom_range(0, 2 * span)) - span);
    s.ux = noisy ? rand_value(span) : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    s.uy = noisy ? rand_value(span) : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    s.vx = noisy ? rand_value(span) : -s.uy;
    s.vy = noisy ? rand_value(span) : s.ux;
    s.hu = noisy ? rand_value(span) : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    s.hv = noisy ? rand_value(span) : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    return s;
  endfunction

  function automatic shape_t make_box(bit second, logic [31:0] cx, logic [31:0] cy,
                                      logic [31:0] ux, logic [31:0] uy, logic [31:0] vx,
                                      logic [31:0] vy, logic [31:0] hu, logic [31:0] hv);
    shape_t s;
    s.is_second = second;
    s.cx = cx;
    s.cy = cy;
    s.ux = ux;
    s.uy = uy;
    s.vx = vx;
    s.vy = vy;
    s.hu = hu;
    s.hv = hv;
    return s;
  endfunction

  task automatic test_directed();
    // A test before any first box runs against the all-zero reset box.
    send_box(make_box(1, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000));
    send_box(make_box(1, 32'h50000, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000));
    send_box(make_box(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000));
    send_box(make_box(1, 32'h18000, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000));
    send_box(make_box(1, 32'h20000, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000));
    send_box(make_box(1, 32'h20001, 0, 32'h30000, 0, 0, 32'h7000, 32'hFFFF0000,
                      32'hFFFF0000));
    send_box(make_box(1, 32'h28000, 32'h28000, 32'h10000, 32'h10000, 32'hFFFF0000,
                      32'h10000, 32'h10000, 32'h10000));
    // Zero axes never separate.
    send_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_box(make_box(1, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0, 0, 0));
    send_box(make_box(1, 32'h7FFFFFFF, 32'h80000000, 32'h10000, 0, 0, 0, 0, 0));
    // Extremes of every field, to reach saturation of differences and radii.
    send_box(make_box(0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                      32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF));
    send_box(make_box(1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000));
    send_box(make_box(1, 32'h80000000, 32'h7FFFFFFF, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1,
                      32'h7FFFFFFF, 32'h7FFFFFFF));
    send_box(make_box(0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1,
                      32'hFFFFFFFF, 1));
    send_box(make_box(1, 32'hFFFFFFFF, 1, 32'h80000000, 0, 0, 32'h80000000, 1,
                      32'hFFFFFFFF));
    send_box(make_box(1, 32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA,
                      32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA));
  endtask

  task automatic test_random_pairs(input int pairs);
    int k;
    repeat (pairs) begin
      send_box(rand_box(0, $urandom_range(0, 9) == 0));
      k = $urandom_range(1, 3);
      repeat (k) send_box(rand_box(1, $urandom_range(0, 9) == 0));
      // Now and then a stray test or two first boxes in a row.
      if ($urandom_range(0, 9) == 0) send_box(rand_box($urandom_range(0, 1), 1));
    end
  endtask

  task automatic test_back_pressure();
    long_hold = 1'b1;
    test_random_pairs(6);
  endtask

  always begin : result_checker
    int  n;
    bit  expected;
    if (long_hold) begin
      out_tready <= 1'b0;
      repeat (3000) @(posedge clk);
      long_hold = 1'b0;
    end else if (rx_stalls) begin
      n = $urandom_range(0, 16);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
    out_tready <= 1'b1;
    do @(posedge clk); while (out_tvalid !== 1'b1);
    if (overlap_q.size() == 0) begin
      $display("%0t: result transfer with nothing expected, actual overlap=%0b", $time,
               out_tdata[0]);
      errors++;
    end else begin
      expected = overlap_q.pop_front();
      if (out_tdata[0] !== expected) begin
        $display("%0t: overlap mismatch, expected %0b, actual %0b", $time, expected,
                 out_tdata[0]);
        errors++;
      end
    end
  end

  initial begin
    held_cx = 0; held_cy = 0; held_ux = 0; held_uy = 0;
    held_vx = 0; held_vy = 0; held_hu = 0; held_hv = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_pairs(220);
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    test_random_pairs(50);
    tx_gaps = 1'b1;
    test_back_pressure();
    rx_stalls = 1'b1;
    test_random_pairs(250);
    in_tvalid <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/obb_pkg.sv
hw/rtl/obb_front.sv
hw/rtl/obb_back.sv
hw/rtl/obb_overlap_test_2d_core.sv
tb/sv/tb_obb_overlap_test_2d_core.sv
